### sv/assert_macros.svh
// Assertion macros shared by the RTL files of the column stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define TCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked at every clock edge outside reset; cons may use ## delays.
`define TCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);
`else
`define TCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/tcs_pkg.sv
// Shared widths, reset values, register indexes and control types of the column stepper.
package tcs_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int SCREEN_W   = 12;
    localparam int TEX_DIM_W  = 11;
    localparam int COL_X_W    = 12;
    localparam int COL_H_W    = 16;
    localparam int HIT_W      = 16;
    localparam int TEX_ID_W   = 2;
    localparam int PIX_Y_W    = 11;
    localparam int TEXEL_W    = 10;
    localparam int ACC_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [SCREEN_W-1:0]  SCREEN_H_RST = 12'd480;
    localparam logic [SCREEN_W-1:0]  MAX_SCREEN   = 12'd2048;
    localparam logic [TEX_DIM_W-1:0] TEX_DIM_RST  = 11'd64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 2'd2;

    // Input item kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    typedef struct packed {
        logic load_start;
        logic div_step;
        logic mul_load;
        logic acc_load;
        logic row_step;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
    } t_dp_status;

endpackage

### sv/textured_column_stepper.sv
// Top level of the textured wall column stepper: controller plus datapath.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------------------
//  config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//  item     | in        | i_valid / o_stall   | i_kind, i_column_x, i_column_height,
//           |           |                     | i_hit_fraction, i_texture_id
//  result   | out       | o_valid / i_stall   | o_pixel_x, o_pixel_y, o_texel_x, o_texel_y,
//           |           |                     | o_tex_select, o_last_row
//
// Rows stream at one transfer per clock while the result side keeps up; the result
// register is freed in the same cycle it is taken.
// A start item holds the block busy while the texture step comes out of a restoring
// divider that yields one quotient bit per cycle, followed by the multiply of the skipped
// rows and the load of the accumulator.
// Reset is synchronous and active low; it clears the control state and the three
// configuration registers to 480, 64 and 64 rows/texels, and holds o_stall high.
// A stall on the result side holds the pending result and blocks row items; start items
// are still taken while a result waits.
module textured_column_stepper #(
    parameter int FRAC_BITS = tcs_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_kind,
    input  logic [tcs_pkg::COL_X_W-1:0]    i_column_x,
    input  logic [tcs_pkg::COL_H_W-1:0]    i_column_height,
    input  logic [tcs_pkg::HIT_W-1:0]      i_hit_fraction,
    input  logic [tcs_pkg::TEX_ID_W-1:0]   i_texture_id,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tcs_pkg::COL_X_W-1:0]    o_pixel_x,
    output logic [tcs_pkg::PIX_Y_W-1:0]    o_pixel_y,
    output logic [tcs_pkg::TEXEL_W-1:0]    o_texel_x,
    output logic [tcs_pkg::TEXEL_W-1:0]    o_texel_y,
    output logic [tcs_pkg::TEX_ID_W-1:0]   o_tex_select,
    output logic                           o_last_row
);
    import tcs_pkg::*;

    // Commands from the controller and the column status back from the datapath.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The controller owns the handshakes and steps the datapath through the start
    // sequence; a row transfer is only issued while a column is active.
    tcs_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // The datapath holds the configuration, the column state, the divider and the
    // result registers.
    tcs_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_column_x      (i_column_x),
        .i_column_height (i_column_height),
        .i_hit_fraction  (i_hit_fraction),
        .i_texture_id    (i_texture_id),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_texel_x       (o_texel_x),
        .o_texel_y       (o_texel_y),
        .o_tex_select    (o_tex_select),
        .o_last_row      (o_last_row)
    );

endmodule

### sv/tcs_ctrl.sv
// Controller of the column stepper: handshakes, start sequencing and output valid.
`include "assert_macros.svh"
module tcs_ctrl #(
    parameter int FRAC_BITS = tcs_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    output logic                o_valid,
    input  logic                i_stall,
    input  tcs_pkg::t_dp_status i_status,
    output tcs_pkg::t_dp_cmd    o_cmd
);
    import tcs_pkg::*;

    localparam int DW    = TEX_DIM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_ACC} t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               out_free;
    logic               accept;
    logic               start_go;
    logic               row_go;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !i_rst_n || (r_state != S_IDLE) || ((i_kind == KIND_ROW) && !out_free);
    assign accept   = i_valid && !o_stall;
    assign start_go = accept && (i_kind == KIND_START);
    assign row_go   = accept && (i_kind == KIND_ROW) && i_status.active;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (row_go) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (start_go) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DW - 1)) begin
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_start = start_go;
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.mul_load   = (r_state == S_MUL);
        o_cmd.acc_load   = (r_state == S_ACC);
        o_cmd.row_step   = row_go;
    end

    assign o_valid = r_out_valid;

    `TCS_ASSERT_IMPLY(a_start_len, i_clk, i_rst_n, start_go, ##(DW + 3) (r_state == S_IDLE), "start sequence length is off")
    `TCS_ASSERT(a_valid_src, i_clk, i_rst_n, !$rose(r_out_valid) || $past(row_go), "result appeared without a row transfer")

endmodule

### sv/tcs_datapath.sv
// Datapath of the column stepper: configuration, divider, accumulator and result registers.
`include "assert_macros.svh"
module tcs_datapath #(
    parameter int FRAC_BITS = tcs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [tcs_pkg::COL_X_W-1:0]       i_column_x,
    input  logic [tcs_pkg::COL_H_W-1:0]       i_column_height,
    input  logic [tcs_pkg::HIT_W-1:0]         i_hit_fraction,
    input  logic [tcs_pkg::TEX_ID_W-1:0]      i_texture_id,
    input  tcs_pkg::t_dp_cmd                  i_cmd,
    output tcs_pkg::t_dp_status               o_status,
    output logic [tcs_pkg::COL_X_W-1:0]       o_pixel_x,
    output logic [tcs_pkg::PIX_Y_W-1:0]       o_pixel_y,
    output logic [tcs_pkg::TEXEL_W-1:0]       o_texel_x,
    output logic [tcs_pkg::TEXEL_W-1:0]       o_texel_y,
    output logic [tcs_pkg::TEX_ID_W-1:0]      o_tex_select,
    output logic                              o_last_row
);
    import tcs_pkg::*;

    localparam int DW     = TEX_DIM_W + FRAC_BITS;
    localparam int TIW    = ACC_W - FRAC_BITS;
    localparam int CW     = (TIW > TEX_DIM_W) ? TIW : TEX_DIM_W;
    localparam int SKIP_W = COL_H_W - 1;
    localparam int PROD_W = SKIP_W + ACC_W;
    localparam int TXP_W  = TEX_DIM_W + HIT_W;
    localparam logic [CW-1:0] TEXEL_MAX_C = CW'({TEXEL_W{1'b1}});

    // Configuration registers.
    logic [SCREEN_W-1:0]  r_screen_height;
    logic [TEX_DIM_W-1:0] r_tex_width;
    logic [TEX_DIM_W-1:0] r_tex_height;

    // Column state.
    logic                 r_active;
    logic                 r_pend_active;
    logic [COL_X_W-1:0]   r_cur_col;
    logic [PIX_Y_W-1:0]   r_cur_row;
    logic [SCREEN_W-1:0]  r_end_row;
    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     r_step;
    logic [TEXEL_W-1:0]   r_col_texel_x;
    logic [TEX_ID_W-1:0]  r_col_tex;
    logic [SKIP_W-1:0]    r_skip;
    logic [COL_H_W-1:0]   r_ch;
    logic [DW-1:0]        r_quo;
    logic [COL_H_W-1:0]   r_rem;
    logic [PROD_W-1:0]    r_prod;

    // Result registers.
    logic [COL_X_W-1:0]   r_pixel_x;
    logic [PIX_Y_W-1:0]   r_pixel_y;
    logic [TEXEL_W-1:0]   r_texel_x;
    logic [TEXEL_W-1:0]   r_texel_y;
    logic [TEX_ID_W-1:0]  r_tex_select;
    logic                 r_last_row;

    // Start item geometry.
    logic [SCREEN_W-1:0]  h_eff;
    logic [COL_H_W:0]     hc_sum;
    logic [COL_H_W-1:0]   ymax_raw;
    logic [SCREEN_W-1:0]  ymax;
    logic                 h_ge;
    logic [COL_H_W-1:0]   diff_pos;
    logic [COL_H_W-1:0]   diff_neg;
    logic [PIX_Y_W-1:0]   start_row;
    logic [SKIP_W-1:0]    skip;
    logic                 pend_active;
    logic [TXP_W-1:0]     tx_prod;
    logic [TEX_DIM_W-1:0] tx_int;
    logic [TEXEL_W-1:0]   tx;

    // Divider, step and accumulator.
    logic [COL_H_W:0]      trial;
    logic                  q_bit;
    logic [DW+ACC_W-1:0]   quo_ext;
    logic [ACC_W-1:0]      step_next;
    logic [PROD_W-1:0]     prod;
    logic [ACC_W-1:0]      acc_init;
    logic [ACC_W:0]        acc_sum;
    logic [ACC_W-1:0]      acc_adv;

    // Row results.
    logic [CW-1:0]         ti_c;
    logic [CW-1:0]         thm1_c;
    logic [CW-1:0]         ty_c;
    logic [TEXEL_W-1:0]    ty;
    logic                  last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= SCREEN_H_RST;
            r_tex_width     <= TEX_DIM_RST;
            r_tex_height    <= TEX_DIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[SCREEN_W-1:0];
                CFG_TEX_WIDTH:     r_tex_width     <= i_cfg_data[TEX_DIM_W-1:0];
                CFG_TEX_HEIGHT:    r_tex_height    <= i_cfg_data[TEX_DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        h_eff     = (r_screen_height > MAX_SCREEN) ? MAX_SCREEN : r_screen_height;
        hc_sum    = (COL_H_W+1)'(h_eff) + (COL_H_W+1)'(i_column_height);
        ymax_raw  = hc_sum[COL_H_W:1];
        ymax      = (ymax_raw > COL_H_W'(h_eff)) ? h_eff : ymax_raw[SCREEN_W-1:0];
        h_ge      = COL_H_W'(h_eff) >= i_column_height;
        diff_pos  = COL_H_W'(h_eff) - i_column_height;
        diff_neg  = i_column_height - COL_H_W'(h_eff);
        // Rows above the screen are skipped but still advance the accumulator.
        start_row = h_ge ? diff_pos[PIX_Y_W:1] : '0;
        skip      = h_ge ? '0 : diff_neg[COL_H_W-1:1];
        pend_active = SCREEN_W'(start_row) < ymax;
        // The scaled hit is always below the width, so no wrap is needed.
        tx_prod   = TXP_W'(r_tex_width) * TXP_W'(i_hit_fraction);
        tx_int    = tx_prod[TXP_W-1:HIT_W];
        tx        = (tx_int > TEX_DIM_W'({TEXEL_W{1'b1}})) ? {TEXEL_W{1'b1}}
                                                           : tx_int[TEXEL_W-1:0];
    end

    always_comb begin
        trial     = {r_rem, r_quo[DW-1]};
        q_bit     = trial >= {1'b0, r_ch};
        quo_ext   = (DW+ACC_W)'(r_quo);
        if (r_ch == '0) begin
            step_next = '0;
        end else if (|quo_ext[DW+ACC_W-1:ACC_W]) begin
            step_next = '1;
        end else begin
            step_next = quo_ext[ACC_W-1:0];
        end
        prod      = PROD_W'(r_skip) * PROD_W'(step_next);
        acc_init  = (|r_prod[PROD_W-1:ACC_W]) ? '1 : r_prod[ACC_W-1:0];
        acc_sum   = {1'b0, r_acc} + {1'b0, r_step};
        acc_adv   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    end

    always_comb begin
        ti_c   = CW'(r_acc[ACC_W-1:FRAC_BITS]);
        thm1_c = CW'(r_tex_height) - CW'(1);
        if (r_tex_height == '0) begin
            ty_c = '0;
        end else if (ti_c > thm1_c) begin
            ty_c = thm1_c;
        end else begin
            ty_c = ti_c;
        end
        ty   = (ty_c > TEXEL_MAX_C) ? {TEXEL_W{1'b1}} : ty_c[TEXEL_W-1:0];
        last = (SCREEN_W'(r_cur_row) + SCREEN_W'(1)) >= r_end_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.load_start) begin
            r_active <= 1'b0;
        end else if (i_cmd.acc_load) begin
            r_active <= r_pend_active;
        end else if (i_cmd.row_step && last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_cur_col     <= i_column_x;
            r_col_tex     <= i_texture_id;
            r_col_texel_x <= tx;
            r_cur_row     <= start_row;
            r_end_row     <= ymax;
            r_skip        <= skip;
            r_pend_active <= pend_active;
            r_ch          <= i_column_height;
            r_quo         <= {r_tex_height, {FRAC_BITS{1'b0}}};
            r_rem         <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? COL_H_W'(trial - {1'b0, r_ch}) : trial[COL_H_W-1:0];
            r_quo <= {r_quo[DW-2:0], q_bit};
        end
        if (i_cmd.mul_load) begin
            r_step <= step_next;
            r_prod <= prod;
        end
        if (i_cmd.acc_load) begin
            r_acc <= acc_init;
        end
        if (i_cmd.row_step) begin
            r_pixel_x    <= r_cur_col;
            r_pixel_y    <= r_cur_row;
            r_texel_x    <= r_col_texel_x;
            r_texel_y    <= ty;
            r_tex_select <= r_col_tex;
            r_last_row   <= last;
            r_cur_row    <= r_cur_row + 1'b1;
            r_acc        <= acc_adv;
        end
    end

    assign o_status.active = r_active;
    assign o_pixel_x       = r_pixel_x;
    assign o_pixel_y       = r_pixel_y;
    assign o_texel_x       = r_texel_x;
    assign o_texel_y       = r_texel_y;
    assign o_tex_select    = r_tex_select;
    assign o_last_row      = r_last_row;

    `TCS_ASSERT_IMPLY(a_acc_mono, i_clk, i_rst_n, i_cmd.row_step, ##1 (r_acc >= $past(r_acc)), "accumulator went backward")
    `TCS_ASSERT_IMPLY(a_no_skip_acc, i_clk, i_rst_n, i_cmd.acc_load && (r_skip == '0), ##1 (r_acc == '0), "accumulator not zero without skipped rows")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the textured wall column stepper with an in-order texel scoreboard.
module testbench;

    // The block is built with its default number of fraction bits in the texture accumulator.
    localparam int FRAC = tcs_pkg::FRAC_BITS_DEF;

    // A start transfer keeps the block busy while the divider and the skip multiply run.
    // Register writes are held back this long after the last transfer.
    localparam int START_CYCLES  = 11 + FRAC + 3;
    localparam int SETTLE_CYCLES = START_CYCLES + 10;

    // Cycles without any transfer or register write before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // Rough size of the random part, counted in items that start or step a column.
    localparam int TARGET_ITEMS = 1300;

    // Only this many error lines are printed. Further errors are still counted.
    localparam int MAX_SHOWN = 200;

    // One pixel/texel pair as the block reports it.
    typedef struct packed {
        logic [tcs_pkg::COL_X_W-1:0]  pixel_x;
        logic [tcs_pkg::PIX_Y_W-1:0]  pixel_y;
        logic [tcs_pkg::TEXEL_W-1:0]  texel_x;
        logic [tcs_pkg::TEXEL_W-1:0]  texel_y;
        logic [tcs_pkg::TEX_ID_W-1:0] tex_select;
        logic                         last_row;
    } texel_t;

    // Scoreboard for the column walk.
    // It keeps its own copy of the registers and of the column state, and it predicts
    // the texel of every accepted row item that finds a live column. It then checks the
    // texels that leave the block in order.
    class texel_tracker;
        logic [tcs_pkg::SCREEN_W-1:0]  scr_h;
        logic [tcs_pkg::TEX_DIM_W-1:0] tex_w;
        logic [tcs_pkg::TEX_DIM_W-1:0] tex_h;

        bit                            col_live;
        logic [tcs_pkg::COL_X_W-1:0]   col_x;
        logic [tcs_pkg::PIX_Y_W-1:0]   row_now;
        logic [tcs_pkg::SCREEN_W-1:0]  row_stop;
        logic [tcs_pkg::ACC_W-1:0]     acc;
        logic [tcs_pkg::ACC_W-1:0]     step;
        logic [tcs_pkg::TEXEL_W-1:0]   tx_col;
        logic [tcs_pkg::TEX_ID_W-1:0]  tex_id;

        texel_t pending_texels[$];
        int     fail_count;

        function new();
            scr_h      = tcs_pkg::SCREEN_H_RST;
            tex_w      = tcs_pkg::TEX_DIM_RST;
            tex_h      = tcs_pkg::TEX_DIM_RST;
            col_live   = 1'b0;
            col_x      = '0;
            row_now    = '0;
            row_stop   = '0;
            acc        = '0;
            step       = '0;
            tx_col     = '0;
            tex_id     = '0;
            fail_count = 0;
        endfunction

        function logic [31:0] clip32(longint unsigned v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
        endfunction

        // The texture registers keep only their low 11 bits of the write data.
        function void write_register(logic [tcs_pkg::CFG_IDX_W-1:0] idx,
                                     logic [tcs_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tcs_pkg::CFG_SCREEN_HEIGHT: scr_h = data;
                tcs_pkg::CFG_TEX_WIDTH:     tex_w = data[tcs_pkg::TEX_DIM_W-1:0];
                tcs_pkg::CFG_TEX_HEIGHT:    tex_h = data[tcs_pkg::TEX_DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Visible rows that the active column still has to produce.
        function int rows_left();
            return col_live ? int'(row_stop) - int'(row_now) : 0;
        endfunction

        function void take_item(logic kind, logic [tcs_pkg::COL_X_W-1:0] x,
                                logic [tcs_pkg::COL_H_W-1:0] height,
                                logic [tcs_pkg::HIT_W-1:0] hit,
                                logic [tcs_pkg::TEX_ID_W-1:0] id);
            longint unsigned h, ch, ymax, skip, first, tx, ty;
            longint          diff;
            texel_t          t;
            bit              last;
            if (kind == tcs_pkg::KIND_START) begin
                h  = (scr_h > tcs_pkg::MAX_SCREEN) ? tcs_pkg::MAX_SCREEN : scr_h;
                ch = height;
                tx = 0;
                if (tex_w != 0) begin
                    tx = (64'(tex_w) * 64'(hit)) >> 16;
                    tx = tx % tex_w;
                    if (tx > 1023)
                        tx = 1023;
                end
                tx_col = 10'(tx);
                tex_id = id;
                col_x  = x;
                step   = (ch != 0) ? clip32((64'(tex_h) << FRAC) / ch) : 32'd0;
                ymax = (h + ch) >> 1;
                if (ymax > h)
                    ymax = h;
                // The top row is the half difference rounded toward zero. Rows above the
                // screen are skipped, but the accumulator still moves past them.
                diff = longint'(h) - longint'(ch);
                if (diff < 0) begin
                    skip  = -(diff / 2);
                    first = 0;
                end else begin
                    skip  = 0;
                    first = diff / 2;
                end
                acc      = clip32(skip * step);
                row_now  = 11'(first);
                row_stop = 12'(ymax);
                col_live = first < ymax;
            end else if (col_live) begin
                ty = acc >> FRAC;
                if (tex_h == 0)
                    ty = 0;
                else if (ty > tex_h - 1)
                    ty = tex_h - 1;
                if (ty > 1023)
                    ty = 1023;
                last = (int'(row_now) + 1) >= int'(row_stop);
                t.pixel_x    = col_x;
                t.pixel_y    = row_now;
                t.texel_x    = tx_col;
                t.texel_y    = 10'(ty);
                t.tex_select = tex_id;
                t.last_row   = last;
                pending_texels.push_back(t);
                row_now = row_now + 1'b1;
                acc     = clip32(64'(acc) + 64'(step));
                if (last)
                    col_live = 1'b0;
            end
        endfunction

        task report(string what);
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display("ERROR at %0t: %s", $time, what);
        endtask

        task check_texel(texel_t got);
            texel_t want;
            if (pending_texels.size() == 0) begin
                report($sformatf("unexpected texel for pixel (%0d,%0d)",
                                 got.pixel_x, got.pixel_y));
                return;
            end
            want = pending_texels.pop_front();
            if (got.pixel_x !== want.pixel_x)
                report($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
            if (got.texel_x !== want.texel_x)
                report($sformatf("texel_x %0d, expected %0d", got.texel_x, want.texel_x));
            if (got.texel_y !== want.texel_y)
                report($sformatf("texel_y %0d, expected %0d", got.texel_y, want.texel_y));
            if (got.tex_select !== want.tex_select)
                report($sformatf("tex_select %0d, expected %0d",
                                 got.tex_select, want.tex_select));
            if (got.last_row !== want.last_row)
                report($sformatf("last_row %0d, expected %0d at row %0d",
                                 got.last_row, want.last_row, want.pixel_y));
        endtask
    endclass

    // All inputs of the block have known values from time zero.
    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_cfg_we        = 1'b0;
    logic [tcs_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [tcs_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                           i_valid         = 1'b0;
    logic                           i_kind          = tcs_pkg::KIND_START;
    logic [tcs_pkg::COL_X_W-1:0]    i_column_x      = '0;
    logic [tcs_pkg::COL_H_W-1:0]    i_column_height = '0;
    logic [tcs_pkg::HIT_W-1:0]      i_hit_fraction  = '0;
    logic [tcs_pkg::TEX_ID_W-1:0]   i_texture_id    = '0;
    logic                           i_stall         = 1'b0;

    logic                           o_stall;
    logic                           o_valid;
    logic [tcs_pkg::COL_X_W-1:0]    o_pixel_x;
    logic [tcs_pkg::PIX_Y_W-1:0]    o_pixel_y;
    logic [tcs_pkg::TEXEL_W-1:0]    o_texel_x;
    logic [tcs_pkg::TEXEL_W-1:0]    o_texel_y;
    logic [tcs_pkg::TEX_ID_W-1:0]   o_tex_select;
    logic                           o_last_row;

    texel_tracker sb = new();

    // When this is set, neither side inserts idle cycles, so rows stream back to back.
    bit steady      = 1'b0;
    int items_sent  = 0;
    int long_walks  = 0;
    int idle_cycles = 0;

    textured_column_stepper uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_column_x      (i_column_x),
        .i_column_height (i_column_height),
        .i_hit_fraction  (i_hit_fraction),
        .i_texture_id    (i_texture_id),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_texel_x       (o_texel_x),
        .o_texel_y       (o_texel_y),
        .o_tex_select    (o_tex_select),
        .o_last_row      (o_last_row)
    );

    // The clock period is 4 ns.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Each side draws a number of idle cycles before every transfer. At least a quarter of
    // the draws are zero, so that back-to-back transfers also occur in idling phases.
    function automatic int draw_gap();
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // The column height is drawn around the effective screen height. Most columns are
    // partly or fully visible; some are empty, tiny or have random bits.
    function automatic logic [tcs_pkg::COL_H_W-1:0] pick_height();
        int h;
        h = (sb.scr_h > tcs_pkg::MAX_SCREEN) ? int'(tcs_pkg::MAX_SCREEN) : int'(sb.scr_h);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'($urandom);
            2:       return 16'($urandom_range(1, 4));
            3:       return 16'(h + $urandom_range(0, 3));
            default: return 16'($urandom_range(1, 2 * h + 8));
        endcase
    endfunction

    function automatic logic [tcs_pkg::TEX_DIM_W-1:0] pick_tex_dim();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 11'd2047;
            2:       return 11'($urandom);
            default: return 11'($urandom_range(1, 1024));
        endcase
    endfunction

    // Drives one item and returns once it has been accepted. Inputs change at the falling
    // edge. Acceptance is sampled at the rising edge. Valid stays high into the next item
    // when that item has no gap.
    task automatic drive_item(logic kind, logic [tcs_pkg::COL_X_W-1:0] x,
                              logic [tcs_pkg::COL_H_W-1:0] height,
                              logic [tcs_pkg::HIT_W-1:0] hit,
                              logic [tcs_pkg::TEX_ID_W-1:0] id);
        int gap;
        gap = draw_gap();
        // Row items that find no active column are ignored by the block and are not counted.
        if (kind == tcs_pkg::KIND_START || sb.rows_left() > 0)
            items_sent++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_column_x      <= x;
        i_column_height <= height;
        i_hit_fraction  <= hit;
        i_texture_id    <= id;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.take_item(kind, x, height, hit, id);
    endtask

    // A row item carries random values in the fields that it does not use.
    task automatic row_item();
        drive_item(tcs_pkg::KIND_ROW, 12'($urandom), 16'($urandom), 16'($urandom),
                   2'($urandom));
    endtask

    // The sender stops and waits until every predicted texel has left the block.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_texels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tcs_pkg::CFG_IDX_W-1:0] idx,
                             logic [tcs_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_register(idx, data);
    endtask

    // Registers change only while the block is idle. All texels must be out, and a start
    // that produced no texel must have had time to finish its divide.
    // The unused top data bit of the texture registers is driven at random.
    task automatic apply_settings(logic [tcs_pkg::SCREEN_W-1:0] sh,
                                  logic [tcs_pkg::TEX_DIM_W-1:0] tw,
                                  logic [tcs_pkg::TEX_DIM_W-1:0] th);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(tcs_pkg::CFG_SCREEN_HEIGHT, sh);
        write_reg(tcs_pkg::CFG_TEX_WIDTH, {1'($urandom), tw});
        write_reg(tcs_pkg::CFG_TEX_HEIGHT, {1'($urandom), th});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A start with random content followed by the rows it should take. Tall columns are
    // mostly cut short, and the next start replaces them. At most two are walked to their last
    // row. Some walks stop early on purpose. Some overrun into rows that the block must ignore.
    task automatic walk_column();
        int n, extra;
        drive_item(tcs_pkg::KIND_START, 12'($urandom), pick_height(), 16'($urandom),
                   2'($urandom));
        n = sb.rows_left();
        if (n > 64) begin
            if (long_walks < 2 && $urandom_range(0, 1) == 1)
                long_walks++;
            else
                n = $urandom_range(1, 40);
        end else if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(0, n);
        end
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n + extra) row_item();
    endtask

    // Random result-side stall. Each texel is accepted after a drawn number of stall cycles.
    initial begin : texel_sink
        int     hold;
        texel_t got;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = draw_gap();
            if (hold > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (hold - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got = '{o_pixel_x, o_pixel_y, o_texel_x, o_texel_y, o_tex_select, o_last_row};
            sb.check_texel(got);
        end
    end

    // The run is hung if no transfer and no register write happen for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
            || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                            phase;
        int                            budget;
        logic [tcs_pkg::SCREEN_W-1:0]  sh;
        logic [tcs_pkg::TEX_DIM_W-1:0] tw;
        logic [tcs_pkg::TEX_DIM_W-1:0] th;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset settings of 480 rows and 64x64 texels.
        // A row with no active column must give nothing.
        row_item();
        // A one-pixel column at the lowest field values gives a single last row. The next
        // row finds the column closed.
        drive_item(tcs_pkg::KIND_START, 12'h000, 16'd1, 16'h0000, 2'd0);
        row_item();
        row_item();
        // All fields at their maximum: a column far taller than the screen, with many rows
        // skipped above it.
        drive_item(tcs_pkg::KIND_START, 12'hFFF, 16'hFFFF, 16'hFFFF, 2'd3);
        row_item();
        row_item();
        // A zero height leaves the block inactive, even while a column is still open.
        drive_item(tcs_pkg::KIND_START, 12'hAAA, 16'd0, 16'h5555, 2'd1);
        row_item();
        // Exactly the screen height, then replaced by a new start after two rows.
        drive_item(tcs_pkg::KIND_START, 12'h555, 16'd480, 16'h8000, 2'd2);
        row_item();
        row_item();
        // A two-row column walked to its end and one row past it.
        drive_item(tcs_pkg::KIND_START, 12'h001, 16'd2, 16'hAAAA, 2'd1);
        row_item();
        row_item();
        row_item();
        // An odd height just above the screen needs the rounding toward zero.
        drive_item(tcs_pkg::KIND_START, 12'h7FF, 16'd481, 16'h7FFF, 2'd2);
        row_item();
        drive_item(tcs_pkg::KIND_START, 12'h800, 16'd960, 16'h0001, 2'd0);
        row_item();
        items_sent = 0;

        // Random phases. The first phases use the extreme settings, including a zero screen,
        // a clamped screen height, zero texture sizes and widths above 1024. Later phases mostly
        // use short screens, so that many columns are walked down to their last row.
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            case (phase)
                0: begin sh = 12'd0;    tw = 11'd0;    th = 11'd0;    end
                1: begin sh = 12'd1;    tw = 11'd1;    th = 11'd1;    end
                2: begin sh = 12'd4095; tw = 11'd2047; th = 11'd2047; end
                3: begin sh = 12'd2048; tw = 11'd1024; th = 11'd1024; end
                4: begin sh = 12'd2049; tw = 11'd1025; th = 11'd1;    end
                default: begin
                    case ($urandom_range(0, 7))
                        0:       sh = 12'($urandom);
                        1:       sh = tcs_pkg::SCREEN_H_RST;
                        default: sh = 12'($urandom_range(1, 48));
                    endcase
                    tw = pick_tex_dim();
                    th = pick_tex_dim();
                end
            endcase
            apply_settings(sh, tw, th);
            steady = ($urandom_range(0, 3) == 0);
            budget = items_sent + ((phase < 5) ? 60 : 100);
            while (items_sent < budget) begin
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                if ($urandom_range(0, 9) < 7) begin
                    walk_column();
                end else if ($urandom_range(0, 1) == 0) begin
                    row_item();
                end else begin
                    drive_item(tcs_pkg::KIND_START, 12'($urandom), 16'($urandom),
                               16'($urandom), 2'($urandom));
                end
            end
            phase++;
        end

        // Let every predicted texel come out. Then wait long enough for anything stray to show.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (sb.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/tcs_pkg.sv
sv/tcs_ctrl.sv
sv/tcs_datapath.sv
sv/textured_column_stepper.sv
tb/testbench.sv
